### src/hptr_pkg.sv
package hptr_pkg;

  // Command codes of the input channel
  typedef enum logic [1:0] {
    CMD_LOAD_TRACE = 2'd0,
    CMD_LOAD_CHAR  = 2'd1,
    CMD_QUERY      = 2'd2
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_WEIGHT  = 2'd1;
  localparam logic [1:0] CFG_LEVEL   = 2'd2;

  localparam logic [31:0] MODULUS_RST = 32'd4294967291;
  localparam logic [7:0]  WEIGHT_RST  = 8'd2;
  localparam logic [10:0] LEVEL_RST   = 11'd1;

  // Remainder unit: narrow operands are 12 bits, wide dividends 64 bits
  localparam int NARROW_W = 12;
  localparam int WIDE_W   = 64;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] index;
    logic [31:0] value;
    logic [11:0] m_index;
    logic [11:0] n_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] trace_sum;
    logic        out_of_range;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic        narrow;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_D_TEST,
    ST_W_M,
    ST_W_N,
    ST_W_C,
    ST_G_TEST,
    ST_W_G,
    ST_RD,
    ST_RD_W,
    ST_P_TEST,
    ST_MUL,
    ST_MOD,
    ST_MOD_W,
    ST_NEXT,
    ST_FIN
  } state_t;

  // What a modular product is for
  typedef enum logic [1:0] {
    OP_PW,
    OP_PB,
    OP_Z1,
    OP_Z2
  } op_t;

endpackage

### src/hptr_ram.sv
module hptr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/hptr_div.sv
module hptr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  hptr_pkg::div_req_t req,
  output hptr_pkg::div_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [31:0] rem_r;
  logic [63:0] dvd_r;
  logic [31:0] dsr_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // one restoring step per cycle while busy
  assign trial = {rem_r, dvd_r[63]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 7'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // quotient bits shift in at the bottom of the dividend
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dsr_r <= req.divisor;
      if (req.narrow) begin
        dvd_r <= {req.dividend[hptr_pkg::NARROW_W-1:0],
                  {(hptr_pkg::WIDE_W - hptr_pkg::NARROW_W){1'b0}}};
        cnt_r <= 7'(hptr_pkg::NARROW_W);
      end else begin
        dvd_r <= req.dividend;
        cnt_r <= 7'(hptr_pkg::WIDE_W);
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : trial[31:0];
      dvd_r <= {dvd_r[62:0], ge};
      cnt_r <= cnt_r - 7'd1;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

### src/hecke_product_trace_mod_p_unit.sv
// Product Hecke trace unit, arithmetic modulo a configured prime p.
// Input channel (in_valid / in_stall / in_item): a beat is a load of the
// trace table, a load of the character table, or a query (m, n). Loads give
// no result. A query gives one result beat on the output channel (out_valid /
// out_stall / out_item): the trace of Tm Tn mod p, or the out_of_range flag
// with a zero sum when m*n does not fit the trace table; such a query skips
// the divisor loop. Otherwise it tries each candidate divisor d up to min(m,n)
// (the nonzero index when the other is zero) with narrow remainders for two
// divisibility tests and d mod level, Euclid steps for gcd(d, level), and,
// for each divisor that counts, modular products: one per bit of weight-1
// below the top one, one per set bit, and two more for the term. One shared
// remainder unit serves all of these; one query is worked at a time and
// in_stall stays high while it runs. Configuration (cfg_valid / cfg_ready) is
// always ready; the user must see that it is written only while the unit is
// idle, as the unit itself does not enforce this. Reset sets modulus, weight
// and level to their defaults and empties the output register; table
// contents are undefined until loaded. A stalled result is held in the
// output register while the unit goes on taking loads and the next query.
module hecke_product_trace_mod_p_unit #(
  parameter int TRACE_DEPTH = 4096,
  parameter int LEVEL_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hptr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output hptr_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int TAW = $clog2(TRACE_DEPTH);
  localparam int LAW = $clog2(LEVEL_DEPTH);
  localparam logic [31:0] TRACE_LAST  = 32'(TRACE_DEPTH - 1);
  localparam logic [31:0] TRACE_LIMIT = 32'(TRACE_DEPTH);
  localparam logic [31:0] LEVEL_LIMIT = 32'(LEVEL_DEPTH);

  // configuration
  logic [31:0] modulus_r;
  logic [7:0]  weight_r;
  logic [10:0] level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= hptr_pkg::MODULUS_RST;
      weight_r  <= hptr_pkg::WEIGHT_RST;
      level_r   <= hptr_pkg::LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hptr_pkg::CFG_MODULUS: modulus_r <= cfg_data;
        hptr_pkg::CFG_WEIGHT:  weight_r  <= cfg_data[7:0];
        hptr_pkg::CFG_LEVEL:   level_r   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  hptr_pkg::state_t state_r, state_nxt;
  hptr_pkg::op_t    op_r, op_nxt;
  logic [11:0] m_r, m_nxt, n_r, n_nxt, lim_r, lim_nxt;
  logic [12:0] d_r, d_nxt;
  logic [11:0] qm_r, qm_nxt, qn_r, qn_nxt;
  logic [10:0] ci_r, ci_nxt;
  logic [11:0] ga_r, ga_nxt, gb_r, gb_nxt;
  logic [31:0] tval_r, tval_nxt, chi_r, chi_nxt;
  logic [31:0] pw_r, pw_nxt, pb_r, pb_nxt;
  logic [7:0]  ex_r, ex_nxt;
  logic [31:0] x_r, x_nxt, y_r, y_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic        oor_r, oor_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_sum_r, out_sum_nxt;
  logic        out_oor_r, out_oor_nxt;

  logic [10:0] lvl;
  logic        p_small;
  logic [23:0] mn;
  logic [23:0] ti;
  logic [32:0] acc;
  logic [31:0] in_idx_ext;
  logic [31:0] ti_ext;
  logic [31:0] ci_ext;

  hptr_pkg::div_req_t div_req;
  hptr_pkg::div_rsp_t div_rsp;

  logic            trace_we, char_we;
  logic [31:0]     trace_rdata, char_rdata;

  assign lvl        = (level_r == 11'd0) ? 11'd1 : level_r;
  assign p_small    = modulus_r < 32'd2;
  assign mn         = m_r * n_r;
  assign ti         = qm_r * qn_r;
  assign acc        = {1'b0, sum_r} + {1'b0, div_rsp.rem};
  assign in_idx_ext = {20'd0, in_item.index};
  assign ti_ext     = {8'd0, ti};
  assign ci_ext     = {21'd0, ci_r};

  // tables
  hptr_ram #(.WIDTH(32), .DEPTH(TRACE_DEPTH)) u_trace_ram (
    .clk   (clk),
    .we    (trace_we),
    .waddr (in_idx_ext[TAW-1:0]),
    .wdata (in_item.value),
    .raddr (ti_ext[TAW-1:0]),
    .rdata (trace_rdata)
  );

  hptr_ram #(.WIDTH(32), .DEPTH(LEVEL_DEPTH)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (in_idx_ext[LAW-1:0]),
    .wdata (in_item.value),
    .raddr (ci_ext[LAW-1:0]),
    .rdata (char_rdata)
  );

  hptr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer: divisor loop, Euclid steps, square-and-multiply
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    lim_nxt       = lim_r;
    d_nxt         = d_r;
    qm_nxt        = qm_r;
    qn_nxt        = qn_r;
    ci_nxt        = ci_r;
    ga_nxt        = ga_r;
    gb_nxt        = gb_r;
    tval_nxt      = tval_r;
    chi_nxt       = chi_r;
    pw_nxt        = pw_r;
    pb_nxt        = pb_r;
    ex_nxt        = ex_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_sum_nxt   = out_sum_r;
    out_oor_nxt   = out_oor_r;
    div_req       = '0;
    trace_we      = 1'b0;
    char_we       = 1'b0;

    unique case (state_r)
      hptr_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_item.cmd == hptr_pkg::CMD_LOAD_TRACE) begin
            trace_we = in_idx_ext < TRACE_LIMIT;
          end else if (in_item.cmd == hptr_pkg::CMD_LOAD_CHAR) begin
            char_we = in_idx_ext < LEVEL_LIMIT;
          end else if (in_item.cmd == hptr_pkg::CMD_QUERY) begin
            m_nxt     = in_item.m_index;
            n_nxt     = in_item.n_index;
            state_nxt = hptr_pkg::ST_CHECK;
          end
        end
      end
      hptr_pkg::ST_CHECK: begin
        oor_nxt = {8'd0, mn} > TRACE_LAST;
        sum_nxt = '0;
        d_nxt   = 13'd1;
        // loop bound is gcd(m,n) or above; a zero index leaves the other
        if (m_r == 12'd0) begin
          lim_nxt = n_r;
        end else if (n_r == 12'd0) begin
          lim_nxt = m_r;
        end else begin
          lim_nxt = (m_r < n_r) ? m_r : n_r;
        end
        state_nxt = (oor_nxt || p_small) ? hptr_pkg::ST_FIN : hptr_pkg::ST_D_TEST;
      end
      hptr_pkg::ST_D_TEST: begin
        if (d_r > {1'b0, lim_r}) begin
          state_nxt = hptr_pkg::ST_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.narrow   = 1'b1;
          div_req.dividend = 64'(m_r);
          div_req.divisor  = 32'(d_r);
          state_nxt        = hptr_pkg::ST_W_M;
        end
      end
      hptr_pkg::ST_W_M: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != 32'd0) begin
            state_nxt = hptr_pkg::ST_NEXT;
          end else begin
            qm_nxt           = div_rsp.quo[11:0];
            div_req.start    = 1'b1;
            div_req.narrow   = 1'b1;
            div_req.dividend = 64'(n_r);
            div_req.divisor  = 32'(d_r);
            state_nxt        = hptr_pkg::ST_W_N;
          end
        end
      end
      hptr_pkg::ST_W_N: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != 32'd0) begin
            state_nxt = hptr_pkg::ST_NEXT;
          end else begin
            qn_nxt           = div_rsp.quo[11:0];
            div_req.start    = 1'b1;
            div_req.narrow   = 1'b1;
            div_req.dividend = 64'(d_r);
            div_req.divisor  = 32'(lvl);
            state_nxt        = hptr_pkg::ST_W_C;
          end
        end
      end
      hptr_pkg::ST_W_C: begin
        // d mod level doubles as the first Euclid step
        if (div_rsp.done) begin
          ci_nxt    = div_rsp.rem[10:0];
          ga_nxt    = {1'b0, lvl};
          gb_nxt    = div_rsp.rem[11:0];
          state_nxt = hptr_pkg::ST_G_TEST;
        end
      end
      hptr_pkg::ST_G_TEST: begin
        if (gb_r == 12'd0) begin
          state_nxt = (ga_r == 12'd1) ? hptr_pkg::ST_RD : hptr_pkg::ST_NEXT;
        end else begin
          div_req.start    = 1'b1;
          div_req.narrow   = 1'b1;
          div_req.dividend = 64'(ga_r);
          div_req.divisor  = 32'(gb_r);
          state_nxt        = hptr_pkg::ST_W_G;
        end
      end
      hptr_pkg::ST_W_G: begin
        if (div_rsp.done) begin
          ga_nxt    = gb_r;
          gb_nxt    = div_rsp.rem[11:0];
          state_nxt = hptr_pkg::ST_G_TEST;
        end
      end
      hptr_pkg::ST_RD: begin
        // addresses come from qm*qn and ci, read data lands next cycle
        state_nxt = hptr_pkg::ST_RD_W;
      end
      hptr_pkg::ST_RD_W: begin
        tval_nxt  = trace_rdata;
        chi_nxt   = (ci_ext < LEVEL_LIMIT) ? char_rdata : 32'd0;
        pw_nxt    = 32'd1;
        pb_nxt    = 32'(d_r[11:0]);
        ex_nxt    = weight_r - 8'd1;
        state_nxt = hptr_pkg::ST_P_TEST;
      end
      hptr_pkg::ST_P_TEST: begin
        if (ex_r == 8'd0) begin
          x_nxt  = tval_r;
          y_nxt  = pw_r;
          op_nxt = hptr_pkg::OP_Z1;
        end else if (ex_r[0]) begin
          x_nxt  = pw_r;
          y_nxt  = pb_r;
          op_nxt = hptr_pkg::OP_PW;
        end else begin
          x_nxt  = pb_r;
          y_nxt  = pb_r;
          op_nxt = hptr_pkg::OP_PB;
        end
        state_nxt = hptr_pkg::ST_MUL;
      end
      hptr_pkg::ST_MUL: begin
        prod_nxt  = x_r * y_r;
        state_nxt = hptr_pkg::ST_MOD;
      end
      hptr_pkg::ST_MOD: begin
        div_req.start    = 1'b1;
        div_req.narrow   = 1'b0;
        div_req.dividend = prod_r;
        div_req.divisor  = modulus_r;
        state_nxt        = hptr_pkg::ST_MOD_W;
      end
      hptr_pkg::ST_MOD_W: begin
        if (div_rsp.done) begin
          unique case (op_r)
            hptr_pkg::OP_PW: begin
              pw_nxt = div_rsp.rem;
              if (ex_r == 8'd1) begin
                ex_nxt    = 8'd0;
                state_nxt = hptr_pkg::ST_P_TEST;
              end else begin
                x_nxt     = pb_r;
                y_nxt     = pb_r;
                op_nxt    = hptr_pkg::OP_PB;
                state_nxt = hptr_pkg::ST_MUL;
              end
            end
            hptr_pkg::OP_PB: begin
              pb_nxt    = div_rsp.rem;
              ex_nxt    = ex_r >> 1;
              state_nxt = hptr_pkg::ST_P_TEST;
            end
            hptr_pkg::OP_Z1: begin
              x_nxt     = div_rsp.rem;
              y_nxt     = chi_r;
              op_nxt    = hptr_pkg::OP_Z2;
              state_nxt = hptr_pkg::ST_MUL;
            end
            hptr_pkg::OP_Z2: begin
              sum_nxt   = (acc >= {1'b0, modulus_r}) ?
                          32'(acc - {1'b0, modulus_r}) : acc[31:0];
              state_nxt = hptr_pkg::ST_NEXT;
            end
            default: ;
          endcase
        end
      end
      hptr_pkg::ST_NEXT: begin
        d_nxt     = d_r + 13'd1;
        state_nxt = hptr_pkg::ST_D_TEST;
      end
      hptr_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = sum_r;
          out_oor_nxt   = oor_r;
          state_nxt     = hptr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hptr_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hptr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    m_r       <= m_nxt;
    n_r       <= n_nxt;
    lim_r     <= lim_nxt;
    d_r       <= d_nxt;
    qm_r      <= qm_nxt;
    qn_r      <= qn_nxt;
    ci_r      <= ci_nxt;
    ga_r      <= ga_nxt;
    gb_r      <= gb_nxt;
    tval_r    <= tval_nxt;
    chi_r     <= chi_nxt;
    pw_r      <= pw_nxt;
    pb_r      <= pb_nxt;
    ex_r      <= ex_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    prod_r    <= prod_nxt;
    sum_r     <= sum_nxt;
    oor_r     <= oor_nxt;
    out_sum_r <= out_sum_nxt;
    out_oor_r <= out_oor_nxt;
  end

  assign in_stall              = state_r != hptr_pkg::ST_IDLE;
  assign out_valid             = out_valid_r;
  assign out_item.trace_sum    = out_sum_r;
  assign out_item.out_of_range = out_oor_r;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("remainder unit restarted while busy");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == hptr_pkg::ST_W_M || state_r == hptr_pkg::ST_W_N ||
                      state_r == hptr_pkg::ST_W_C || state_r == hptr_pkg::ST_W_G ||
                      state_r == hptr_pkg::ST_MOD_W))
    else $error("remainder finished with nobody waiting");

  a_trace_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hptr_pkg::ST_RD |-> ti_ext < TRACE_LIMIT)
    else $error("trace read beyond table");

  a_sum_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hptr_pkg::ST_FIN && !p_small) |-> sum_r < modulus_r)
    else $error("sum not reduced");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hptr_pkg::ST_FIN && oor_r) |-> sum_r == 32'd0)
    else $error("out of range result with nonzero sum");
`endif

endmodule
